// ===== design/srf_pkg.sv =====
`default_nettype none

package srf_pkg;

	// field widths of one beat
	localparam int TS_W  = 32;
	localparam int ID_W  = 8;
	localparam int VAL_W = 32;
	localparam int CAP_W = 9;
	localparam int CNT_W = 32;

	// default store depth and capacity after reset
	localparam int DEPTH_DEFAULT = 256;
	localparam int CAP_RESET     = 256;

	// request codes
	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_PEEK  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_type_t;

	// one stored record
	typedef struct packed {
		logic [TS_W-1:0]  ts;
		logic [ID_W-1:0]  id;
		logic [VAL_W-1:0] val;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// status of one request, carried from control to output stage
	typedef struct packed {
		logic             ok;
		logic             use_rd;
		logic [CAP_W-1:0] fill_count;
		logic             is_full;
		logic             buf_empty;
		logic             overflow_seen;
		logic [CNT_W-1:0] overflow_total;
	} status_t;

endpackage

`default_nettype wire

// ===== design/srf_req_if.sv =====
`default_nettype none

interface srf_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                req_type;
	logic [srf_pkg::TS_W-1:0]  wr_timestamp;
	logic [srf_pkg::ID_W-1:0]  wr_sensor_id;
	logic [srf_pkg::VAL_W-1:0] wr_value;

	modport source (
		output valid, req_type, wr_timestamp, wr_sensor_id, wr_value,
		input  ready
	);

	modport sink (
		input  valid, req_type, wr_timestamp, wr_sensor_id, wr_value,
		output ready
	);
endinterface

`default_nettype wire

// ===== design/srf_rsp_if.sv =====
`default_nettype none

interface srf_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      ok;
	logic [srf_pkg::TS_W-1:0]  rd_timestamp;
	logic [srf_pkg::ID_W-1:0]  rd_sensor_id;
	logic [srf_pkg::VAL_W-1:0] rd_value;
	logic [srf_pkg::CAP_W-1:0] fill_count;
	logic                      is_full;
	logic                      buf_empty;
	logic                      overflow_seen;
	logic [srf_pkg::CNT_W-1:0] overflow_total;

	modport source (
		output valid, ok, rd_timestamp, rd_sensor_id, rd_value, fill_count,
		       is_full, buf_empty, overflow_seen, overflow_total,
		input  ready
	);

	modport sink (
		input  valid, ok, rd_timestamp, rd_sensor_id, rd_value, fill_count,
		       is_full, buf_empty, overflow_seen, overflow_total,
		output ready
	);
endinterface

`default_nettype wire

// ===== design/sample_record_fifo_top.sv =====
// channel  dir  handshake      payload
// req      in   valid/ready    req_type, wr_timestamp, wr_sensor_id, wr_value
// rsp      out  valid/ready    ok, rd_*, fill_count, is_full, buf_empty, overflow_*
// cfg      in   cfg_we         cfg_wdata (capacity_in_use)
//
// one request beat per cycle while rsp is not stalled; the response passes the record
// memory read register (stage 1) and then the output register.
// fifo pointers and counters update at acceptance, so the next beat sees them.
// arst_n clears pointers, counters, flag and valids; record memory is not cleared.
// a stalled rsp holds the output register, the beat behind it waits in stage 1.
`default_nettype none

module sample_record_fifo_top #(
	parameter int DEPTH = srf_pkg::DEPTH_DEFAULT
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	srf_req_if.sink                        req,
	srf_rsp_if.source                      rsp,
	input  wire logic                      cfg_we,
	input  wire logic [srf_pkg::CAP_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(DEPTH);

	logic                      adv;
	logic                      ram_we, ram_re;
	logic [AW-1:0]             ram_waddr, ram_raddr;
	logic [srf_pkg::REC_W-1:0] ram_wdata, ram_rdata;
	logic                      valid_s1;
	srf_pkg::status_t          status_s1;

	// pointers, counters and request decode
	srf_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.adv       (adv),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.valid_s1  (valid_s1),
		.status_s1 (status_s1)
	);

	// record store
	srf_ram #(
		.WIDTH(srf_pkg::REC_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// response register
	srf_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.status_s1 (status_s1),
		.rdata     (ram_rdata),
		.adv       (adv),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== design/srf_ram.sv =====
`default_nettype none

module srf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, output holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/srf_ctrl.sv =====
`default_nettype none

module srf_ctrl #(
	parameter int DEPTH = srf_pkg::DEPTH_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	srf_req_if.sink                            req,
	input  wire logic                          cfg_we,
	input  wire logic [srf_pkg::CAP_W-1:0]     cfg_wdata,
	input  wire logic                          adv,
	output logic                               ram_we,
	output logic      [$clog2(DEPTH)-1:0]      ram_waddr,
	output logic      [srf_pkg::REC_W-1:0]     ram_wdata,
	output logic                               ram_re,
	output logic      [$clog2(DEPTH)-1:0]      ram_raddr,
	output logic                               valid_s1,
	output srf_pkg::status_t                   status_s1
);

	localparam int AW = $clog2(DEPTH);
	localparam int MW = (AW + 1 > srf_pkg::CAP_W) ? AW + 1 : srf_pkg::CAP_W;
	localparam logic [AW:0] DEPTH_N = (AW + 1)'(DEPTH);
	localparam logic [srf_pkg::CAP_W-1:0] DEPTH_CAP =
		(DEPTH > 511) ? 9'd511 : srf_pkg::CAP_W'(DEPTH);
	localparam logic [srf_pkg::CAP_W-1:0] CAP_RST =
		(DEPTH < srf_pkg::CAP_RESET) ? srf_pkg::CAP_W'(DEPTH)
		                             : srf_pkg::CAP_W'(srf_pkg::CAP_RESET);

	logic [srf_pkg::CAP_W-1:0] cap_q;
	logic [AW-1:0]             wslot_q, wslot_d;
	logic [AW-1:0]             rslot_q, rslot_d;
	logic [srf_pkg::CAP_W-1:0] held_q, held_d;
	logic [srf_pkg::CNT_W-1:0] total_q, total_d;
	logic                      sticky_q, sticky_d;
	logic                      accept;
	logic                      ok_d, use_rd_d, we_d, re_d;
	logic [srf_pkg::CAP_W-1:0] cap_cfg;
	srf_pkg::rec_t             rec_in;

	// slot advance with wrap at capacity or depth
	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s,
	                                            input logic [srf_pkg::CAP_W-1:0] cap);
		logic [AW:0] n;
		n = {1'b0, s} + (AW + 1)'(1);
		if (MW'(n) >= MW'(cap) || n >= DEPTH_N) begin
			next_slot = '0;
		end else begin
			next_slot = n[AW-1:0];
		end
	endfunction

	assign req.ready = !valid_s1 || adv;
	assign accept    = req.valid && req.ready;

	// clamp of a capacity write
	always_comb begin
		if (cfg_wdata == '0) begin
			cap_cfg = srf_pkg::CAP_W'(1);
		end else if (cfg_wdata > DEPTH_CAP) begin
			cap_cfg = DEPTH_CAP;
		end else begin
			cap_cfg = cfg_wdata;
		end
	end

	// request decode and next state
	always_comb begin
		wslot_d  = wslot_q;
		rslot_d  = rslot_q;
		held_d   = held_q;
		total_d  = total_q;
		sticky_d = sticky_q;
		ok_d     = 1'b0;
		use_rd_d = 1'b0;
		we_d     = 1'b0;
		re_d     = 1'b0;
		case (srf_pkg::req_type_t'(req.req_type))
			srf_pkg::REQ_WRITE: begin
				if (held_q >= cap_q) begin
					total_d  = total_q + srf_pkg::CNT_W'(1);
					sticky_d = 1'b1;
				end else begin
					we_d    = 1'b1;
					wslot_d = next_slot(wslot_q, cap_q);
					held_d  = held_q + srf_pkg::CAP_W'(1);
					ok_d    = 1'b1;
				end
			end
			srf_pkg::REQ_READ: begin
				if (held_q != '0) begin
					re_d     = 1'b1;
					ok_d     = 1'b1;
					use_rd_d = 1'b1;
					rslot_d  = next_slot(rslot_q, cap_q);
					held_d   = held_q - srf_pkg::CAP_W'(1);
				end
			end
			srf_pkg::REQ_PEEK: begin
				if (held_q != '0) begin
					re_d     = 1'b1;
					ok_d     = 1'b1;
					use_rd_d = 1'b1;
				end
			end
			srf_pkg::REQ_CLEAR: begin
				wslot_d = '0;
				rslot_d = '0;
				held_d  = '0;
				ok_d    = 1'b1;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	// memory access for the accepted beat
	assign rec_in.ts  = req.wr_timestamp;
	assign rec_in.id  = req.wr_sensor_id;
	assign rec_in.val = req.wr_value;
	assign ram_we     = accept && we_d;
	assign ram_waddr  = wslot_q;
	assign ram_wdata  = rec_in;
	assign ram_re     = accept && re_d;
	assign ram_raddr  = rslot_q;

	// fifo state and capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RST;
			wslot_q  <= '0;
			rslot_q  <= '0;
			held_q   <= '0;
			total_q  <= '0;
			sticky_q <= 1'b0;
		end else if (accept) begin
			wslot_q  <= wslot_d;
			rslot_q  <= rslot_d;
			held_q   <= held_d;
			total_q  <= total_d;
			sticky_q <= sticky_d;
		end else if (cfg_we && held_q == '0) begin
			cap_q   <= cap_cfg;
			wslot_q <= '0;
			rslot_q <= '0;
		end
	end

	// stage 1 valid, waits here for the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 status payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1.ok             <= ok_d;
			status_s1.use_rd         <= use_rd_d;
			status_s1.fill_count     <= held_d;
			status_s1.is_full        <= (held_d == cap_q);
			status_s1.buf_empty      <= (held_d == '0);
			status_s1.overflow_seen  <= sticky_d;
			status_s1.overflow_total <= total_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/srf_out_stage.sv =====
`default_nettype none

module srf_out_stage (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      valid_s1,
	input  wire srf_pkg::status_t          status_s1,
	input  wire logic [srf_pkg::REC_W-1:0] rdata,
	output logic                           adv,
	srf_rsp_if.source                      rsp
);

	srf_pkg::rec_t rec_rd;
	logic          valid_q;

	assign rec_rd = srf_pkg::rec_t'(rdata);
	assign adv    = !valid_q || rsp.ready;

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_s1;
		end
	end

	// output payload, data fields zero unless a record was read
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			rsp.ok             <= status_s1.ok;
			rsp.rd_timestamp   <= status_s1.use_rd ? rec_rd.ts  : '0;
			rsp.rd_sensor_id   <= status_s1.use_rd ? rec_rd.id  : '0;
			rsp.rd_value       <= status_s1.use_rd ? rec_rd.val : '0;
			rsp.fill_count     <= status_s1.fill_count;
			rsp.is_full        <= status_s1.is_full;
			rsp.buf_empty      <= status_s1.buf_empty;
			rsp.overflow_seen  <= status_s1.overflow_seen;
			rsp.overflow_total <= status_s1.overflow_total;
		end
	end

	assign rsp.valid = valid_q;

endmodule

`default_nettype wire
